// File: rtl/aabb_frustum_cull_defines.svh
// Assertion macros shared by the frustum cull RTL.
// No dependencies; included by the files that carry concurrent checks.
`ifndef AABB_FRUSTUM_CULL_DEFINES_SVH
`define AABB_FRUSTUM_CULL_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AFC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/afc_pkg.sv
// Shared types and constants of the frustum cull block.
// No dependencies; imported by every module of the block.
package afc_pkg;

	localparam int DEF_COORD_BITS = 24;
	localparam int ENTRY_W        = 32;
	localparam int PLANE_W        = ENTRY_W + 1;
	localparam int NUM_PLANES     = 6;
	localparam int NUM_REGS       = 8;
	localparam int CFG_IDX_BITS   = 4;
	localparam int CFG_DATA_W     = 64;
	localparam int REG_SEL_BITS   = $clog2(NUM_REGS);

	// Register indexes
	localparam logic [REG_SEL_BITS-1:0] REG_COL0_ROWS01 = 3'd0;
	localparam logic [REG_SEL_BITS-1:0] REG_COL0_ROWS23 = 3'd1;
	localparam logic [REG_SEL_BITS-1:0] REG_COL1_ROWS01 = 3'd2;
	localparam logic [REG_SEL_BITS-1:0] REG_COL1_ROWS23 = 3'd3;
	localparam logic [REG_SEL_BITS-1:0] REG_COL2_ROWS01 = 3'd4;
	localparam logic [REG_SEL_BITS-1:0] REG_COL2_ROWS23 = 3'd5;
	localparam logic [REG_SEL_BITS-1:0] REG_COL3_ROWS01 = 3'd6;
	localparam logic [REG_SEL_BITS-1:0] REG_COL3_ROWS23 = 3'd7;

	// Identity matrix at reset: 1.0 in Q16.16 on the diagonal
	localparam logic [CFG_DATA_W-1:0] ONE_LOW_HALF  = 64'h0000_0000_0001_0000;
	localparam logic [CFG_DATA_W-1:0] ONE_HIGH_HALF = 64'h0001_0000_0000_0000;

	typedef logic signed [PLANE_W-1:0] comp_t;
	// Plane components: [0..2] normal, [3] offset
	typedef comp_t [3:0] plane_t;

	typedef struct packed {
		logic en2;
		logic en3;
		logic en4;
	} pipe_ctrl_t;

endpackage

// File: rtl/afc_cfg.sv
// Matrix registers and plane extraction of the frustum cull block.
// Depends on afc_pkg; feeds registered planes to the plane testers.
module afc_cfg import afc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	output plane_t                  planes_q [NUM_PLANES]
);

	logic [CFG_DATA_W-1:0] regs_q [NUM_REGS];
	plane_t                planes_d [NUM_PLANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q[REG_COL0_ROWS01] <= ONE_LOW_HALF;
			regs_q[REG_COL0_ROWS23] <= '0;
			regs_q[REG_COL1_ROWS01] <= ONE_HIGH_HALF;
			regs_q[REG_COL1_ROWS23] <= '0;
			regs_q[REG_COL2_ROWS01] <= '0;
			regs_q[REG_COL2_ROWS23] <= ONE_LOW_HALF;
			regs_q[REG_COL3_ROWS01] <= '0;
			regs_q[REG_COL3_ROWS23] <= ONE_HIGH_HALF;
		end else if (cfg_valid && (cfg_index < CFG_IDX_BITS'(NUM_REGS))) begin
			regs_q[cfg_index[REG_SEL_BITS-1:0]] <= cfg_data;
		end
	end

	// Plane i, component a: m[a][3] +/- m[a][i/2], minus for odd i
	always_comb begin
		logic signed [ENTRY_W-1:0] w;
		logic signed [ENTRY_W-1:0] e;
		for (int i = 0; i < NUM_PLANES; i++) begin
			for (int a = 0; a < 4; a++) begin
				w = $signed(regs_q[2*a + 1][CFG_DATA_W-1 -: ENTRY_W]);
				e = $signed(regs_q[2*a + (i/2)/2][((i/2)%2)*ENTRY_W +: ENTRY_W]);
				if ((i % 2) != 0) begin
					planes_d[i][a] = PLANE_W'(w) - PLANE_W'(e);
				end else begin
					planes_d[i][a] = PLANE_W'(w) + PLANE_W'(e);
				end
			end
		end
	end

	// User must change planes only when idle, unchecked; a register splits adders from multiplies
	always_ff @(posedge clk) begin
		planes_q <= planes_d;
	end

endmodule

// File: rtl/afc_plane_test.sv
// One plane test: corner select and products, partial sums, final sign.
// Depends on afc_pkg; instantiated once per frustum plane by the top level.
module afc_plane_test import afc_pkg::*; #(
	parameter int COORD_BITS = DEF_COORD_BITS
) (
	input  logic                         clk,
	input  pipe_ctrl_t                   ctrl,
	input  plane_t                       plane,
	input  logic signed [COORD_BITS-1:0] lo_s1 [3],
	input  logic signed [COORD_BITS-1:0] hi_s1 [3],
	output logic                         outside_s4
);

	localparam int PROD_W = PLANE_W + COORD_BITS;
	localparam int SUM_W  = PROD_W + 2;

	logic signed [PROD_W-1:0] prod_s2 [3];
	logic signed [PLANE_W-1:0] d_s2;
	logic signed [SUM_W-1:0]  sa_s3;
	logic signed [SUM_W-1:0]  sb_s3;
	logic signed [SUM_W-1:0]  total;

	// Stage 2: pick max for a nonnegative normal component, min otherwise
	always_ff @(posedge clk) begin
		if (ctrl.en2) begin
			for (int a = 0; a < 3; a++) begin
				prod_s2[a] <= PROD_W'($signed(plane[a])) *
					PROD_W'(plane[a][PLANE_W-1] ? lo_s1[a] : hi_s1[a]);
			end
			d_s2 <= $signed(plane[3]);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en3) begin
			sa_s3 <= SUM_W'(prod_s2[0]) + SUM_W'(prod_s2[1]);
			sb_s3 <= SUM_W'(prod_s2[2]) + SUM_W'(d_s2);
		end
	end

	assign total = sa_s3 + sb_s3;

	always_ff @(posedge clk) begin
		if (ctrl.en4) begin
			outside_s4 <= total[SUM_W-1];
		end
	end

endmodule

// File: rtl/aabb_frustum_cull.sv
// Axis-aligned box versus view frustum test, top level.
// Depends on afc_pkg, afc_cfg, afc_plane_test and aabb_frustum_cull_defines.svh.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one box per word: signed
//   integer x, y and z limits of COORD_BITS each. Output channel
//   (out_valid/out_stall) returns one visible bit per box, in order.
//   The configuration channel (cfg_valid/cfg_ready, always ready) writes
//   the 64-bit matrix registers by index; writes beyond index 7 are
//   dropped. Write only while no box is in flight.
//   An accepted box passes the input register, then products, partial
//   sums, and final sum and sign, before out_valid rises. Throughput:
//   one box per cycle while out_stall is low; the 33 x COORD_BITS
//   multipliers of the product stage set the clock, eighteen of them
//   working in parallel.
//   Reset loads the identity matrix and empties the pipeline.
//   A stall on the output holds the last stage; stages behind it keep
//   filling bubbles, and in_stall rises only when every stage is full.
`include "aabb_frustum_cull_defines.svh"
module aabb_frustum_cull import afc_pkg::*; #(
	parameter int COORD_BITS = DEF_COORD_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] x_min,
	input  logic signed [COORD_BITS-1:0] x_max,
	input  logic signed [COORD_BITS-1:0] y_min,
	input  logic signed [COORD_BITS-1:0] y_max,
	input  logic signed [COORD_BITS-1:0] z_min,
	input  logic signed [COORD_BITS-1:0] z_max,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         visible,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data
);

	plane_t     planes_q [NUM_PLANES];
	pipe_ctrl_t ctrl;
	logic       en1;
	logic       v_s1, v_s2, v_s3, v_s4;
	logic signed [COORD_BITS-1:0] lo_s1 [3];
	logic signed [COORD_BITS-1:0] hi_s1 [3];
	logic [NUM_PLANES-1:0] outside_s4;

	assign cfg_ready = 1'b1;

	afc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.planes_q  (planes_q)
	);

	// A stage advances when it is empty or the one ahead advances
	assign ctrl.en4 = !v_s4 || !out_stall;
	assign ctrl.en3 = !v_s3 || ctrl.en4;
	assign ctrl.en2 = !v_s2 || ctrl.en3;
	assign en1      = !v_s1 || ctrl.en2;
	assign in_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1)      v_s1 <= in_valid;
			if (ctrl.en2) v_s2 <= v_s1;
			if (ctrl.en3) v_s3 <= v_s2;
			if (ctrl.en4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			lo_s1[0] <= x_min;
			hi_s1[0] <= x_max;
			lo_s1[1] <= y_min;
			hi_s1[1] <= y_max;
			lo_s1[2] <= z_min;
			hi_s1[2] <= z_max;
		end
	end

	for (genvar i = 0; i < NUM_PLANES; i++) begin : g_plane
		afc_plane_test #(
			.COORD_BITS (COORD_BITS)
		) u_plane (
			.clk        (clk),
			.ctrl       (ctrl),
			.plane      (planes_q[i]),
			.lo_s1      (lo_s1),
			.hi_s1      (hi_s1),
			.outside_s4 (outside_s4[i])
		);
	end

	assign out_valid = v_s4;
	assign visible   = ~|outside_s4;

	`AFC_ASSERT_NOW(a_stall_only_full, clk, arst_n, in_stall,
		v_s1 && v_s2 && v_s3 && v_s4, "input stalled with a free stage")
	`AFC_ASSERT_NEXT(a_accept_lands, clk, arst_n, in_valid && !in_stall,
		v_s1, "accepted word not held in stage 1")
	`AFC_ASSERT_NEXT(a_s3_moves, clk, arst_n, v_s3 && ctrl.en4,
		v_s4, "stage 3 word lost on advance")
	`AFC_ASSERT_NEXT(a_out_held, clk, arst_n, v_s4 && out_stall,
		v_s4 && $stable(outside_s4), "stalled result changed")

endmodule

// File: bench/aabb_frustum_cull_tb.sv
// Self-checking bench for aabb_frustum_cull: streams boxes against a series of matrices
// and checks each visible bit against an exact plane-by-plane prediction.
// Depends on afc_pkg and the aabb_frustum_cull RTL.
module aabb_frustum_cull_tb import afc_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB           = DEF_COORD_BITS;
	localparam int COORD_MAX    = (1 << (CB - 1)) - 1;
	localparam int COORD_MIN    = -(1 << (CB - 1));
	localparam int DRAIN_CYCLES = 8;
	localparam int REPORT_MAX   = 10;

	typedef struct packed {
		logic [2:0][CB-1:0] lo;
		logic [2:0][CB-1:0] hi;
		bit                 hold;   // present only once every earlier result is back
	} box_t;

	typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BURSTY} stall_pat_e;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	logic signed [CB-1:0]  x_min     = '0;
	logic signed [CB-1:0]  x_max     = '0;
	logic signed [CB-1:0]  y_min     = '0;
	logic signed [CB-1:0]  y_max     = '0;
	logic signed [CB-1:0]  z_min     = '0;
	logic signed [CB-1:0]  z_max     = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  visible;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	box_t                  box_q [$];
	box_t                  cur_box;
	logic                  vis_expect [$];
	logic [CFG_DATA_W-1:0] mat_reg [NUM_REGS];
	int                    n_pushed   = 0;
	int                    n_accepted = 0;
	int                    n_results  = 0;
	int                    burst_left = 0;
	int                    gap_left   = 0;
	int                    err_cnt    = 0;
	stall_pat_e            stall_mode = STALL_NONE;
	logic [5:0]            stall_tick = '0;

	aabb_frustum_cull #(.COORD_BITS(CB)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.x_min     (x_min),
		.x_max     (x_max),
		.y_min     (y_min),
		.y_max     (y_max),
		.z_min     (z_min),
		.z_max     (z_max),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.visible   (visible),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	// Signed Q16.16 entry m[col][row] of the shadow matrix.
	function automatic logic signed [31:0] mat_word(int col, int row);
		return mat_reg[col * 2 + row / 2][(row % 2) * 32 +: 32];
	endfunction

	// Plane i: row 3 plus (even i) or minus (odd i) row i/2, tested at the far corner
	// along each normal component; exact, so no rounding anywhere.
	function automatic logic frustum_visible(box_t b);
		comp_t               comp [4];
		logic signed [31:0]  w;
		logic signed [31:0]  e;
		logic signed [127:0] acc;
		logic signed [CB-1:0] p;
		logic                vis;
		vis = 1'b1;
		for (int i = 0; i < NUM_PLANES; i++) begin
			for (int a = 0; a < 4; a++) begin
				w = mat_word(a, 3);
				e = mat_word(a, i / 2);
				comp[a] = i[0] ? w - e : w + e;
			end
			acc = comp[3];
			for (int a = 0; a < 3; a++) begin
				p = (comp[a] >= 0) ? b.hi[a] : b.lo[a];
				acc += comp[a] * p;
			end
			if (acc < 0)
				vis = 1'b0;
		end
		return vis;
	endfunction

	function automatic int clamp_coord(int v);
		return (v > COORD_MAX) ? COORD_MAX : (v < COORD_MIN) ? COORD_MIN : v;
	endfunction

	function automatic box_t mk_box(int x0, int x1, int y0, int y1, int z0, int z1);
		box_t b;
		b.lo[0] = CB'(x0);
		b.hi[0] = CB'(x1);
		b.lo[1] = CB'(y0);
		b.hi[1] = CB'(y1);
		b.lo[2] = CB'(z0);
		b.hi[2] = CB'(z1);
		b.hold  = 1'b0;
		return b;
	endfunction

	// Centers lean toward small magnitudes so boxes straddle planes at every scale.
	function automatic box_t rand_box();
		box_t b;
		int   c;
		int   h;
		int   a;
		int   z;
		for (int ax = 0; ax < 3; ax++) begin
			c = $urandom_range(0, (32'd1 << $urandom_range(0, $urandom_range(0, CB - 1))) - 1);
			if ($urandom_range(0, 1))
				c = -c;
			h = $urandom_range(0, (32'd1 << $urandom_range(0, CB - 1)) - 1);
			a = clamp_coord(c - h);
			z = clamp_coord(c + h);
			case ($urandom_range(0, 15))
				0: begin
					b.lo[ax] = CB'($urandom);
					b.hi[ax] = CB'($urandom);
				end
				1: begin
					// limits out of order
					b.lo[ax] = CB'(z);
					b.hi[ax] = CB'(a);
				end
				default: begin
					b.lo[ax] = CB'(a);
					b.hi[ax] = CB'(z);
				end
			endcase
		end
		b.hold = 1'b0;
		return b;
	endfunction

	// Random sign, random magnitude from zero up to the full Q16.16 range.
	function automatic logic [31:0] rand_entry();
		logic [31:0] mag;
		mag = $urandom & ((32'd1 << $urandom_range(0, 31)) - 1);
		return $urandom_range(0, 1) ? -mag : mag;
	endfunction

	task automatic push_box(box_t b);
		box_q.insert(box_q.size(), b);
		n_pushed++;
	endtask

	task automatic random_boxes(int count);
		box_t b;
		for (int j = 0; j < count; j++) begin
			b = rand_box();
			b.hold = (j == count / 2) || ($urandom_range(0, 99) == 0);
			push_box(b);
		end
	endtask

	task automatic extreme_boxes();
		push_box(mk_box(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
		push_box(mk_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
		push_box(mk_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
	endtask

	// Called right after a rising edge; returns at the edge that took the write.
	task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_matrix(input logic [CFG_DATA_W-1:0] vals [NUM_REGS], input bit junk);
		for (int i = 0; i < NUM_REGS; i++) begin
			cfg_write(CFG_IDX_BITS'(i), vals[i]);
			if (junk && $urandom_range(0, 1))
				cfg_write(CFG_IDX_BITS'($urandom_range(NUM_REGS, 2 ** CFG_IDX_BITS - 1)),
					{$urandom, $urandom});
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		do @(posedge clk); while (n_accepted != n_pushed || n_results != n_pushed);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Driver: bursts of words with random gaps; hold the word while stalled.
	always @(posedge clk) begin
		bit   fire;
		box_t nb;
		fire = in_valid && !in_stall;
		if (!arst_n) begin
			in_valid   <= 1'b0;
			burst_left <= 0;
			gap_left   <= 0;
			n_accepted <= 0;
			mat_reg[REG_COL0_ROWS01] = ONE_LOW_HALF;
			mat_reg[REG_COL0_ROWS23] = '0;
			mat_reg[REG_COL1_ROWS01] = ONE_HIGH_HALF;
			mat_reg[REG_COL1_ROWS23] = '0;
			mat_reg[REG_COL2_ROWS01] = '0;
			mat_reg[REG_COL2_ROWS23] = ONE_LOW_HALF;
			mat_reg[REG_COL3_ROWS01] = '0;
			mat_reg[REG_COL3_ROWS23] = ONE_HIGH_HALF;
		end else begin
			if (cfg_valid && cfg_ready && cfg_index < NUM_REGS)
				mat_reg[cfg_index[REG_SEL_BITS-1:0]] = cfg_data;
			if (fire) begin
				vis_expect.insert(vis_expect.size(), frustum_visible(cur_box));
				n_accepted <= n_accepted + 1;
			end
			if (!in_valid || fire) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (box_q.size() == 0 ||
						(box_q[0].hold && (fire || n_accepted != n_results))) begin
					in_valid <= 1'b0;
				end else begin
					nb = box_q.pop_front();
					cur_box  <= nb;
					x_min    <= nb.lo[0];
					x_max    <= nb.hi[0];
					y_min    <= nb.lo[1];
					y_max    <= nb.hi[1];
					z_min    <= nb.lo[2];
					z_max    <= nb.hi[2];
					in_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 24);
						gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left <= burst_left - 1;
					end
				end
			end
		end
	end

	// Monitor: check each word in order, stall on a random pattern chosen anew when stall_tick wraps.
	always @(posedge clk) begin
		logic want;
		if (!arst_n) begin
			out_stall  <= 1'b0;
			n_results  <= 0;
			stall_mode <= STALL_NONE;
			stall_tick <= '0;
		end else begin
			if (out_valid && !out_stall) begin
				n_results <= n_results + 1;
				if (vis_expect.size() == 0) begin
					if (err_cnt < REPORT_MAX)
						$display("result %0d with nothing pending: visible=%0b", n_results, visible);
					err_cnt++;
				end else begin
					want = vis_expect.pop_front();
					if (visible !== want) begin
						if (err_cnt < REPORT_MAX)
							$display("result %0d: visible expected %0b, got %0b",
								n_results, want, visible);
						err_cnt++;
					end
				end
			end
			stall_tick <= stall_tick + 1'b1;
			if (stall_tick == '1)
				stall_mode <= stall_pat_e'($urandom_range(0, 3));
			case (stall_mode)
				STALL_NONE:  out_stall <= 1'b0;
				STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
				default:     out_stall <= (stall_tick[2:0] < 3'd5);
			endcase
		end
	end

	initial begin
		logic [CFG_DATA_W-1:0] mtx [NUM_REGS];
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// identity after reset: visible exactly when the box meets [-1, 1] on every axis
		push_box(mk_box(0, 0, 0, 0, 0, 0));
		extreme_boxes();
		push_box(mk_box(-1, -1, 0, 0, 0, 0));
		push_box(mk_box(-2, -2, 0, 0, 0, 0));
		push_box(mk_box(1, 1, 0, 0, 0, 0));
		push_box(mk_box(2, 2, 0, 0, 0, 0));
		push_box(mk_box(0, 0, -2, -2, 0, 0));
		push_box(mk_box(0, 0, 2, 2, 0, 0));
		push_box(mk_box(0, 0, 0, 0, -2, -2));
		push_box(mk_box(0, 0, 0, 0, 2, 2));
		push_box(mk_box(3, -3, 0, 0, 0, 0));
		push_box(mk_box(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN));
		random_boxes(100);
		wait_idle();

		// all planes zero: every box passes
		foreach (mtx[i])
			mtx[i] = '0;
		load_matrix(mtx, 1'b0);
		@(negedge clk);
		extreme_boxes();
		random_boxes(20);
		wait_idle();

		// most negative entries: even planes at -2^32, odd planes zero
		foreach (mtx[i])
			mtx[i] = 64'h8000_0000_8000_0000;
		load_matrix(mtx, 1'b0);
		@(negedge clk);
		extreme_boxes();
		random_boxes(40);
		wait_idle();

		// row 3 at max, other rows at min: odd planes reach 2^32 - 1
		foreach (mtx[i])
			mtx[i] = i[0] ? 64'h7FFF_FFFF_8000_0000 : 64'h8000_0000_8000_0000;
		load_matrix(mtx, 1'b0);
		@(negedge clk);
		extreme_boxes();
		random_boxes(40);
		wait_idle();

		for (int ph = 0; ph < 4; ph++) begin
			foreach (mtx[i])
				mtx[i] = {rand_entry(), rand_entry()};
			load_matrix(mtx, 1'b1);
			@(negedge clk);
			random_boxes(150);
			wait_idle();
		end

		foreach (mtx[i])
			mtx[i] = {$urandom, $urandom};
		load_matrix(mtx, 1'b1);
		@(negedge clk);
		random_boxes(100);
		wait_idle();

		if (err_cnt == 0 && vis_expect.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
